// File: src/sbfga_pkg.sv
// Shared types and constants for the serial-bus frame to gamepad axes decoder.
`timescale 1ns / 1ps

package sbfga_pkg;

	// Input beat kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_GAP  = 1'b1;

	// Frame framing bytes and layout
	localparam logic [7:0] START_BYTE = 8'h0F;
	localparam logic [7:0] END_BYTE   = 8'h00;
	localparam int unsigned BODY_LEN  = 23;
	localparam int unsigned COUNT_W   = 5;
	localparam int unsigned FLAG_IDX  = BODY_LEN - 1;
	localparam int unsigned LOST_BIT_POS     = 2;
	localparam int unsigned FAILSAFE_BIT_POS = 3;

	// Channel and axis geometry
	localparam int unsigned CH_W     = 11;
	localparam int unsigned NUM_AXES = 8;
	localparam logic [CH_W-1:0] CH_LOW  = 11'd200;
	localparam logic [CH_W-1:0] CH_HIGH = 11'd1800;

	// Scaling: floor(d * 2047 / 1600) by reciprocal multiply
	localparam int unsigned PROD_W      = 2 * CH_W;
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_W     = 22;
	localparam logic [RECIP_W-1:0] RECIP = 22'd2684355;

	// Register reset value
	localparam logic [NUM_AXES-1:0] REVERSE_RESET = 8'h02;

	// Per-stage move enables of the scaling pipeline
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_out;
	} sbfga_pipe_en_t;

	// Source channel of each output axis, in output order
	function automatic logic [2:0] axis_source(input logic [2:0] axis);
		logic [2:0] ch;
		case (axis)
			3'd0:    ch = 3'd3;
			3'd1:    ch = 3'd2;
			3'd2:    ch = 3'd0;
			3'd3:    ch = 3'd1;
			default: ch = axis;
		endcase
		return ch;
	endfunction

endpackage

// File: src/sbfga_byte_cell.sv
// One byte cell of the frame body shift line.
`timescale 1ns / 1ps

module sbfga_byte_cell (
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] d_in,
	output logic [7:0] d_out
);

	logic [7:0] byte_q;

	// Take the neighbor's byte on each shift
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d_in;
		end
	end

	assign d_out = byte_q;

endmodule

// File: src/sbfga_axis_lane.sv
// One axis lane: clamp, scale to 0..2047 and optional invert, pipelined.
`timescale 1ns / 1ps

module sbfga_axis_lane (
	input  logic                          clk,
	input  sbfga_pkg::sbfga_pipe_en_t     pipe_en,
	input  logic [sbfga_pkg::CH_W-1:0]    raw,
	input  logic                          inv,
	output logic [sbfga_pkg::CH_W-1:0]    axis
);

	import sbfga_pkg::*;

	logic [CH_W-1:0]                clamped;
	logic [CH_W-1:0]                d_s1;
	logic                           inv_s1;
	logic [PROD_W-1:0]              y_s2;
	logic                           inv_s2;
	logic [PROD_W+RECIP_W-1:0]      prod;
	logic [CH_W-1:0]                q_s3;
	logic                           inv_s3;
	logic [CH_W-1:0]                axis_q;

	// Clamp the raw channel into the valid span
	always_comb begin
		if (raw < CH_LOW) begin
			clamped = CH_LOW;
		end else if (raw > CH_HIGH) begin
			clamped = CH_HIGH;
		end else begin
			clamped = raw;
		end
	end

	// Stage 1: offset from the low end
	always_ff @(posedge clk) begin
		if (pipe_en.en_s1) begin
			d_s1   <= clamped - CH_LOW;
			inv_s1 <= inv;
		end
	end

	// Stage 2: times 2047 as shift and subtract
	always_ff @(posedge clk) begin
		if (pipe_en.en_s2) begin
			y_s2   <= {d_s1, {CH_W{1'b0}}} - {{CH_W{1'b0}}, d_s1};
			inv_s2 <= inv_s1;
		end
	end

	// Stage 3: divide by 1600 through the reciprocal
	assign prod = (PROD_W+RECIP_W)'(y_s2) * (PROD_W+RECIP_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (pipe_en.en_s3) begin
			q_s3   <= prod[RECIP_SHIFT +: CH_W];
			inv_s3 <= inv_s2;
		end
	end

	// Output: invert as 2047 minus value
	always_ff @(posedge clk) begin
		if (pipe_en.en_out) begin
			axis_q <= inv_s3 ? ~q_s3 : q_s3;
		end
	end

	assign axis = axis_q;

endmodule

// File: src/sbus_frame_to_gamepad_axes_top.sv
// Top level: frame hunting, body shift line and eight axis scaling lanes.
// Throughput: one input beat per cycle while in_stall is low; a frame is 25 bytes.
// The capture of the end byte moves through stages s1, s2, s3 and the output register.
// Input stalls only while all four scaling stages hold reports and the output is stalled.
// Reset (arst_n low, asynchronous): hunting for start, reverse mask = 8'h02,
// no report pending.
`timescale 1ns / 1ps

module sbus_frame_to_gamepad_axes_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] yaw_axis,
	output logic [10:0] throttle_axis,
	output logic [10:0] roll_axis,
	output logic [10:0] pitch_axis,
	output logic [10:0] aux_a_axis,
	output logic [10:0] aux_b_axis,
	output logic [10:0] aux_c_axis,
	output logic [10:0] aux_d_axis,
	output logic        signal_lost,
	output logic        failsafe
);

	import sbfga_pkg::*;

	logic [NUM_AXES-1:0]      reverse_mask_q;
	logic                     in_frame_q;
	logic [COUNT_W-1:0]       byte_count_q;
	logic                     accept;
	logic                     body_shift;
	logic                     capture;
	logic [7:0]               cell_out [BODY_LEN];
	logic [7:0]               cell_in  [BODY_LEN];
	logic [BODY_LEN*8-1:0]    frame_bits;
	logic                     v_s1, v_s2, v_s3, out_valid_q;
	logic [1:0]               flags_s1, flags_s2, flags_s3, flags_q;
	sbfga_pipe_en_t           pipe_en;
	logic [CH_W-1:0]          axis [NUM_AXES];

	// Reverse mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_mask_q <= REVERSE_RESET;
		end else if (cfg_we) begin
			reverse_mask_q <= cfg_wdata;
		end
	end

	// Beat handshake and frame events
	assign accept     = in_valid && !in_stall;
	assign body_shift = accept && (kind == KIND_BYTE) && in_frame_q
	                    && (byte_count_q < COUNT_W'(BODY_LEN));
	assign capture    = accept && (kind == KIND_BYTE) && in_frame_q
	                    && (byte_count_q == COUNT_W'(BODY_LEN)) && (rx_byte == END_BYTE);

	// Hunt and count frame bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			byte_count_q <= '0;
		end else if (accept) begin
			if (kind == KIND_GAP) begin
				in_frame_q   <= 1'b0;
				byte_count_q <= '0;
			end else if (!in_frame_q) begin
				if (rx_byte == START_BYTE) begin
					in_frame_q   <= 1'b1;
					byte_count_q <= '0;
				end
			end else if (byte_count_q < COUNT_W'(BODY_LEN)) begin
				byte_count_q <= byte_count_q + 1'b1;
			end else begin
				in_frame_q   <= 1'b0;
				byte_count_q <= '0;
			end
		end
	end

	// Body shift line: new byte enters the top cell, each cell hands down
	genvar gi;
	generate
		for (gi = 0; gi < BODY_LEN; gi++) begin : g_cell
			if (gi == BODY_LEN - 1) begin : g_top
				assign cell_in[gi] = rx_byte;
			end else begin : g_mid
				assign cell_in[gi] = cell_out[gi+1];
			end
			sbfga_byte_cell u_cell (
				.clk      (clk),
				.shift_en (body_shift),
				.d_in     (cell_in[gi]),
				.d_out    (cell_out[gi])
			);
			assign frame_bits[gi*8 +: 8] = cell_out[gi];
		end
	endgenerate

	// Stage enables: a stage moves when empty or when the next one moves
	assign pipe_en.en_out = !out_valid_q || !out_stall;
	assign pipe_en.en_s3  = !v_s3 || pipe_en.en_out;
	assign pipe_en.en_s2  = !v_s2 || pipe_en.en_s3;
	assign pipe_en.en_s1  = !v_s1 || pipe_en.en_s2;
	assign in_stall       = !pipe_en.en_s1;

	// Report valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pipe_en.en_s1)  v_s1        <= capture;
			if (pipe_en.en_s2)  v_s2        <= v_s1;
			if (pipe_en.en_s3)  v_s3        <= v_s2;
			if (pipe_en.en_out) out_valid_q <= v_s3;
		end
	end

	// Flag bits travel beside the lanes
	always_ff @(posedge clk) begin
		if (pipe_en.en_s1) begin
			flags_s1 <= {cell_out[FLAG_IDX][FAILSAFE_BIT_POS], cell_out[FLAG_IDX][LOST_BIT_POS]};
		end
		if (pipe_en.en_s2)  flags_s2 <= flags_s1;
		if (pipe_en.en_s3)  flags_s3 <= flags_s2;
		if (pipe_en.en_out) flags_q  <= flags_s3;
	end

	// Axis lanes, each fed from its source channel
	generate
		for (gi = 0; gi < NUM_AXES; gi++) begin : g_lane
			localparam logic [2:0] SRC = axis_source(3'(gi));
			sbfga_axis_lane u_lane (
				.clk     (clk),
				.pipe_en (pipe_en),
				.raw     (frame_bits[SRC*CH_W +: CH_W]),
				.inv     (reverse_mask_q[gi]),
				.axis    (axis[gi])
			);
		end
	endgenerate

	// Drive the report ports
	assign out_valid     = out_valid_q;
	assign yaw_axis      = axis[0];
	assign throttle_axis = axis[1];
	assign roll_axis     = axis[2];
	assign pitch_axis    = axis[3];
	assign aux_a_axis    = axis[4];
	assign aux_b_axis    = axis[5];
	assign aux_c_axis    = axis[6];
	assign aux_d_axis    = axis[7];
	assign signal_lost   = flags_q[0];
	assign failsafe      = flags_q[1];

endmodule
